// ----- hdl/ivsm_pkg.sv -----
`timescale 1ns / 1ps

package ivsm_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned SRC_W      = 5;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PRIO_W     = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 4;
  // internal index widths, wide enough for the largest supported table sizes
  localparam int unsigned SLOT_IDX_W = 5;
  localparam int unsigned SRC_IDX_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_MOVE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_UNASSIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_SAME       = 3'd4
  } status_e;

  typedef struct packed {
    status_e                 status;
    logic                    valid;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [ADDR_W-1:0]       handler;
  } result_t;

  typedef struct packed {
    logic                    clear;
    logic                    mem_we;
    logic                    en_we;
    logic                    en_val;
    logic [SLOT_IDX_W-1:0]   waddr;
    logic [SRC_W-1:0]        wsource;
    logic [ADDR_W-1:0]       waddress;
    logic [SLOT_IDX_W-1:0]   raddr;
  } slot_req_t;

  typedef struct packed {
    logic [SRC_W-1:0]        rsource;
    logic [ADDR_W-1:0]       raddress;
    logic                    ren;
    logic                    free_found;
    logic [SLOT_IDX_W-1:0]   free_idx;
  } slot_rsp_t;

  typedef struct packed {
    logic                    clear;
    logic                    we;
    logic [SRC_IDX_W-1:0]    waddr;
    logic [SLOT_IDX_W-1:0]   wslot;
    logic [SRC_IDX_W-1:0]    raddr;
  } map_req_t;

  typedef struct packed {
    logic                    rhas;
    logic [SLOT_IDX_W-1:0]   rslot;
  } map_rsp_t;

endpackage

// ----- hdl/ivsm_if.sv -----
`timescale 1ns / 1ps

interface ivsm_cmd_if import ivsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [SRC_W-1:0]    irq_source;
  logic [ADDR_W-1:0]   handler_address;
  logic [PRIO_W-1:0]   priority_req;

  modport source (output valid, opcode, irq_source, handler_address, priority_req, input ready);
  modport sink   (input valid, opcode, irq_source, handler_address, priority_req, output ready);
endinterface

interface ivsm_rsp_if import ivsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  slot_valid;
  logic [SLOT_OUT_W-1:0] slot;
  logic [ADDR_W-1:0]     slot_handler;

  modport source (output valid, status, slot_valid, slot, slot_handler, input ready);
  modport sink   (input valid, status, slot_valid, slot, slot_handler, output ready);
endinterface

// ----- hdl/interrupt_vector_slot_manager_unit.sv -----
`timescale 1ns / 1ps

// Interrupt vector slot manager. Keeps SLOT_COUNT vector slots (slot number is
// priority) and a source-to-slot map for SOURCE_COUNT sources.
// cmd_i: one command per transaction (clear, set handler, move, query).
// rsp_o: one result per command: status, whether the source holds a slot,
// that slot and its handler address after the command.
// Where a command finishes and its result is registered for output:
//   clear, set handler and commands rejected as unassigned or full: S_LOOKUP
//   query and moves rejected for range or same slot: S_FETCH
//   successful move: S_SWAP
// A new command is taken only in S_IDLE, once the last one is finished. The
// steps follow the slot memory, which reads one entry a cycle: a move reads
// the target and the source's own slot and writes both back one after the
// other, after a lookup in the map memory.
// Reset clears all enable and map-valid flip-flops at once; the table is
// empty right after reset and no clearing pass is needed.
// A stalled rsp_o holds its result; the next command can still be accepted
// and is finished into a holding register until the output frees up.
module interrupt_vector_slot_manager_unit import ivsm_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = 16,
  parameter int unsigned SOURCE_COUNT = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ivsm_cmd_if.sink   cmd_i,
  ivsm_rsp_if.source rsp_o
);

  slot_req_t slot_req;
  slot_rsp_t slot_rsp;
  map_req_t  map_req;
  map_rsp_t  map_rsp;

  ivsm_slot_store #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (slot_req),
    .rsp_o  (slot_rsp)
  );

  ivsm_map_store #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_map_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  ivsm_ctrl #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .rsp_o      (rsp_o),
    .slot_req_o (slot_req),
    .slot_rsp_i (slot_rsp),
    .map_req_o  (map_req),
    .map_rsp_i  (map_rsp)
  );

endmodule

// ----- hdl/ivsm_slot_store.sv -----
`timescale 1ns / 1ps

module ivsm_slot_store import ivsm_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  slot_req_t req_i,
  output slot_rsp_t rsp_o
);

  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  entry_t                mem_q [SLOT_COUNT];
  entry_t                rd_q;
  logic [SLOT_COUNT-1:0] en_q;
  logic                  ren_q;
  logic                  free_found_d, free_found_q;
  logic [SlotW-1:0]      free_idx_d, free_idx_q;
  logic [SlotW-1:0]      waddr, raddr;

  assign waddr = req_i.waddr[SlotW-1:0];
  assign raddr = req_i.raddr[SlotW-1:0];

  // contents only matter while the enable bit is set, so no clear is needed
  always_ff @(posedge clk_i) begin
    if (req_i.mem_we) begin
      mem_q[waddr] <= '{src: req_i.wsource, addr: req_i.waddress};
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= '0;
      ren_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        en_q <= '0;
      end else if (req_i.en_we) begin
        en_q[waddr] <= req_i.en_val;
      end
      ren_q <= en_q[raddr];
    end
  end

  // lowest free slot, registered for the next lookup
  always_comb begin
    free_found_d = 1'b0;
    free_idx_d   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!en_q[i]) begin
        free_found_d = 1'b1;
        free_idx_d   = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
    end else begin
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
    end
  end

  assign rsp_o.rsource    = rd_q.src;
  assign rsp_o.raddress   = rd_q.addr;
  assign rsp_o.ren        = ren_q;
  assign rsp_o.free_found = free_found_q;
  assign rsp_o.free_idx   = SLOT_IDX_W'(free_idx_q);

endmodule

// ----- hdl/ivsm_map_store.sv -----
`timescale 1ns / 1ps

module ivsm_map_store import ivsm_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = 16,
  parameter int unsigned SOURCE_COUNT = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output map_rsp_t rsp_o
);

  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SrcW  = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

  logic [SlotW-1:0]        mem_q [SOURCE_COUNT];
  logic [SlotW-1:0]        rd_q;
  logic [SOURCE_COUNT-1:0] has_q;
  logic                    rhas_q;
  logic [SrcW-1:0]         waddr, raddr;

  assign waddr = req_i.waddr[SrcW-1:0];
  assign raddr = req_i.raddr[SrcW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr] <= req_i.wslot[SlotW-1:0];
    end
    rd_q <= mem_q[raddr];
  end

  // every map write leaves the source holding a slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q  <= '0;
      rhas_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        has_q <= '0;
      end else if (req_i.we) begin
        has_q[waddr] <= 1'b1;
      end
      rhas_q <= has_q[raddr];
    end
  end

  assign rsp_o.rhas  = rhas_q;
  assign rsp_o.rslot = SLOT_IDX_W'(rd_q);

endmodule

// ----- hdl/ivsm_ctrl.sv -----
`timescale 1ns / 1ps

module ivsm_ctrl import ivsm_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = 16,
  parameter int unsigned SOURCE_COUNT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ivsm_cmd_if.sink          cmd_i,
  ivsm_rsp_if.source        rsp_o,
  output slot_req_t         slot_req_o,
  input  slot_rsp_t         slot_rsp_i,
  output map_req_t          map_req_o,
  input  map_rsp_t          map_rsp_i
);

  localparam logic [PRIO_W:0]  SlotLimit = (PRIO_W + 1)'(SLOT_COUNT);
  localparam logic [SRC_W+1:0] SrcLimit  = (SRC_W + 2)'(SOURCE_COUNT);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_FETCH  = 5'b00100,
    S_SWAP   = 5'b01000,
    S_HOLD   = 5'b10000
  } state_e;

  state_e                state_d, state_q;
  op_e                   op_d, op_q;
  logic [SRC_W-1:0]      src_d, src_q;
  logic [ADDR_W-1:0]     addr_d, addr_q;
  logic [PRIO_W-1:0]     prio_d, prio_q;
  logic [SLOT_IDX_W-1:0] from_d, from_q;
  logic                  to_en_d, to_en_q;
  logic [SRC_W-1:0]      to_src_d, to_src_q;
  logic [ADDR_W-1:0]     to_addr_d, to_addr_q;
  result_t               res_d, res_q;
  result_t               out_d, out_q;
  logic                  out_valid_d, out_valid_q;
  result_t               fin_res;
  logic                  finish, out_free, src_ok, prio_ok;
  slot_req_t             slot_req;
  map_req_t              map_req;

  assign src_ok   = {2'b00, src_q} < SrcLimit;
  assign prio_ok  = {1'b0, prio_q} < SlotLimit;
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    src_d       = src_q;
    addr_d      = addr_q;
    prio_d      = prio_q;
    from_d      = from_q;
    to_en_d     = to_en_q;
    to_src_d    = to_src_q;
    to_addr_d   = to_addr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    finish      = 1'b0;
    fin_res     = '{status: ST_OK, valid: 1'b0, slot: '0, handler: '0};
    slot_req       = '0;
    slot_req.raddr = from_q;
    map_req        = '0;
    map_req.raddr  = SRC_IDX_W'(src_q);

    unique case (state_q)
      S_IDLE: begin
        // reads go out with the transaction so data is there in S_LOOKUP
        slot_req.raddr = SLOT_IDX_W'(cmd_i.priority_req);
        map_req.raddr  = SRC_IDX_W'(cmd_i.irq_source);
        if (cmd_i.valid) begin
          op_d    = op_e'(cmd_i.opcode);
          src_d   = cmd_i.irq_source;
          addr_d  = cmd_i.handler_address;
          prio_d  = cmd_i.priority_req;
          state_d = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        from_d    = map_rsp_i.rslot;
        to_en_d   = slot_rsp_i.ren;
        to_src_d  = slot_rsp_i.rsource;
        to_addr_d = slot_rsp_i.raddress;
        if (op_q == OP_CLEAR) begin
          slot_req.clear = 1'b1;
          map_req.clear  = 1'b1;
          finish         = 1'b1;
        end else if (!src_ok || !map_rsp_i.rhas && op_q != OP_SET) begin
          fin_res.status = ST_UNASSIGNED;
          finish         = 1'b1;
        end else if (op_q == OP_SET) begin
          if (map_rsp_i.rhas || slot_rsp_i.free_found) begin
            slot_req.waddr    = map_rsp_i.rhas ? map_rsp_i.rslot : slot_rsp_i.free_idx;
            slot_req.mem_we   = 1'b1;
            slot_req.en_we    = 1'b1;
            slot_req.en_val   = 1'b1;
            slot_req.wsource  = src_q;
            slot_req.waddress = addr_q;
            map_req.we        = 1'b1;
            map_req.waddr     = SRC_IDX_W'(src_q);
            map_req.wslot     = slot_req.waddr;
            fin_res.valid     = 1'b1;
            fin_res.slot      = SLOT_OUT_W'(slot_req.waddr);
            fin_res.handler   = addr_q;
          end else begin
            fin_res.status = ST_FULL;
          end
          finish = 1'b1;
        end else begin
          // move or query of an assigned source: fetch its own slot
          slot_req.raddr = map_rsp_i.rslot;
          state_d        = S_FETCH;
        end
      end

      S_FETCH: begin
        fin_res.valid   = 1'b1;
        fin_res.slot    = SLOT_OUT_W'(from_q);
        fin_res.handler = slot_rsp_i.raddress;
        if (op_q == OP_QUERY) begin
          finish = 1'b1;
        end else if (!prio_ok) begin
          fin_res.status = ST_RANGE;
          finish         = 1'b1;
        end else if (from_q == prio_q) begin
          fin_res.status = ST_SAME;
          finish         = 1'b1;
        end else begin
          // the source lands in the target slot
          slot_req.waddr    = prio_q;
          slot_req.mem_we   = 1'b1;
          slot_req.en_we    = 1'b1;
          slot_req.en_val   = 1'b1;
          slot_req.wsource  = src_q;
          slot_req.waddress = slot_rsp_i.raddress;
          map_req.we        = 1'b1;
          map_req.waddr     = SRC_IDX_W'(src_q);
          map_req.wslot     = prio_q;
          fin_res.slot      = SLOT_OUT_W'(prio_q);
          res_d             = fin_res;
          state_d           = S_SWAP;
        end
      end

      S_SWAP: begin
        // old slot takes the displaced occupant, or is freed
        slot_req.waddr  = from_q;
        slot_req.en_we  = 1'b1;
        slot_req.en_val = to_en_q;
        if (to_en_q) begin
          slot_req.mem_we   = 1'b1;
          slot_req.wsource  = to_src_q;
          slot_req.waddress = to_addr_q;
          map_req.we        = 1'b1;
          map_req.waddr     = SRC_IDX_W'(to_src_q);
          map_req.wslot     = from_q;
        end
        fin_res = res_q;
        finish  = 1'b1;
      end

      S_HOLD: begin
        fin_res = res_q;
        finish  = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        out_d       = fin_res;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    src_q     <= src_d;
    addr_q    <= addr_d;
    prio_q    <= prio_d;
    from_q    <= from_d;
    to_en_q   <= to_en_d;
    to_src_q  <= to_src_d;
    to_addr_q <= to_addr_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign slot_req_o = slot_req;
  assign map_req_o  = map_req;

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.slot_valid   = out_q.valid;
  assign rsp_o.slot         = out_q.slot;
  assign rsp_o.slot_handler = out_q.handler;

endmodule
